[src/gcvs_pkg.sv]
package gcvs_pkg;

  localparam int DIES_DEF   = 8;
  localparam int BLOCKS_DEF = 1024;
  localparam int PAGES_DEF  = 128;

  localparam int TYPE_W  = 2;
  localparam int DIE_W   = 3;
  localparam int BLK_W   = 10;
  localparam int CNT_W   = 8;
  localparam int SCORE_W = 32;
  localparam int TICK_W  = 32;

  localparam logic [TYPE_W-1:0] REQ_PUT    = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_SELECT = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PUT_RD,
    S_PUT_WR,
    S_PUT_LINK,
    S_RM_RD,
    S_RM_WR,
    S_SEL_HEAD,
    S_SEL_HWAIT,
    S_SEL_BRD,
    S_SEL_MUL,
    S_SEL_MUL2,
    S_SEL_DIV,
    S_SEL_CMP,
    S_SEL_FIN,
    S_RESP
  } state_t;

endpackage

[src/gc_victim_select_cost_benefit_top.sv]
// Garbage-collection victim table: per die, one doubly linked list of blocks for
// each invalid-page count, kept in memories with one registered read port and one
// write port each under a small sequencer. After reset a clearing pass
// initializes the erase ticks and list heads and tails; no request is taken
// meanwhile. Select walks every listed block of the die with a nonzero count
// from the highest count down, reading the head of each count's list and
// scoring each block with a bit-serial restoring divider, then unlinks the
// winner. One request is in flight at a time.
module gc_victim_select_cost_benefit_top #(
  parameter int DIES            = gcvs_pkg::DIES_DEF,
  parameter int BLOCKS_PER_DIE  = gcvs_pkg::BLOCKS_DEF,
  parameter int PAGES_PER_BLOCK = gcvs_pkg::PAGES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  logic [gcvs_pkg::TYPE_W-1:0]  req_type,
  input  logic [gcvs_pkg::DIE_W-1:0]   die,
  input  logic [gcvs_pkg::BLK_W-1:0]   block,
  input  logic [gcvs_pkg::CNT_W-1:0]   invalid_count,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output logic                         victim_found,
  output logic [gcvs_pkg::BLK_W-1:0]   victim_block,
  output logic [gcvs_pkg::SCORE_W-1:0] victim_score
);

  localparam int CW    = gcvs_pkg::CNT_W;
  localparam int TW    = gcvs_pkg::TICK_W;
  localparam int SW    = gcvs_pkg::SCORE_W;
  localparam int OBW   = gcvs_pkg::BLK_W;
  localparam int DW    = (DIES > 1) ? $clog2(DIES) : 1;
  localparam int BIW   = $clog2(BLOCKS_PER_DIE);
  localparam int BW    = $clog2(BLOCKS_PER_DIE + 1);
  localparam int PB    = $clog2(PAGES_PER_BLOCK + 1);
  localparam int SAW   = DW + BIW;
  localparam int BAW   = DW + PB;
  localparam int CLW   = (SAW > BAW) ? SAW : BAW;
  localparam int IPW   = CW + PB;
  localparam int NW    = IPW + TW;
  localparam int RW    = PB + 1;
  localparam int VW    = $clog2(BLOCKS_PER_DIE + 1);
  localparam int DCW   = $clog2(NW + 1);
  localparam logic [BW-1:0] NONE = BW'(BLOCKS_PER_DIE);

  gcvs_pkg::state_t state, state_next;

  // memories
  logic [TW-1:0] tick_mem [2**SAW];
  logic [BW-1:0] next_mem [2**SAW];
  logic [BW-1:0] prev_mem [2**SAW];
  logic [CW-1:0] cnt_mem  [2**SAW];
  logic [BW-1:0] head_mem [2**BAW];
  logic [BW-1:0] tail_mem [2**BAW];

  logic [SAW-1:0] rd_slot;
  logic [BAW-1:0] rd_bkt;
  logic [TW-1:0]  tick_rd;
  logic [BW-1:0]  next_rd, prev_rd, head_rd, tail_rd;
  logic [CW-1:0]  cnt_rd;

  logic           tick_we, next_we, prev_we, cnt_we, head_we, tail_we;
  logic [SAW-1:0] tick_wa, next_wa, prev_wa, cnt_wa;
  logic [BAW-1:0] head_wa, tail_wa;
  logic [TW-1:0]  tick_wd;
  logic [BW-1:0]  next_wd, prev_wd, head_wd, tail_wd;

  // control and datapath registers
  logic [CLW-1:0] clr;
  logic [TW-1:0]  tick;
  logic [DW-1:0]  die_q;
  logic [BIW-1:0] blk_q;
  logic [CW-1:0]  cnt_q;
  logic           sel;
  logic           found;
  logic [SW-1:0]  best;
  logic [PB-1:0]  bkt;
  logic [VW-1:0]  visits;
  logic [BW-1:0]  cur, nx_q, tl_q;
  logic [IPW-1:0] ip_q;
  logic [TW-1:0]  age1_q;
  logic [RW-1:0]  dvs_q, rem;
  logic [NW-1:0]  num;
  logic [SW-1:0]  quo;
  logic [DCW-1:0] dcnt;

  logic           accept, die_ok, blk_ok, cnt_ok, win, last_in_list;
  logic [RW:0]    rem_sh;
  logic [SAW-1:0] slot_q;
  logic [BAW-1:0] put_bkt, rm_bkt;

  assign req_ready    = (state == gcvs_pkg::S_IDLE);
  assign accept       = req_valid && req_ready;
  assign die_ok       = 32'(die) < DIES;
  assign blk_ok       = 32'(block) < BLOCKS_PER_DIE;
  assign cnt_ok       = 32'(invalid_count) <= PAGES_PER_BLOCK;
  assign win          = quo > best;
  assign last_in_list = (nx_q == NONE) || (visits == VW'(BLOCKS_PER_DIE - 1));
  assign rem_sh       = {rem, num[NW-1]};
  assign slot_q       = {die_q, blk_q};
  assign put_bkt      = {die_q, PB'(cnt_q)};
  assign rm_bkt       = {die_q, PB'(cnt_rd)};

  always_ff @(posedge clk) begin
    if (tick_we) tick_mem[tick_wa] <= tick_wd;
    tick_rd <= tick_mem[rd_slot];
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    next_rd <= next_mem[rd_slot];
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    prev_rd <= prev_mem[rd_slot];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_q;
    cnt_rd <= cnt_mem[rd_slot];
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd <= head_mem[rd_bkt];
  end

  always_ff @(posedge clk) begin
    if (tail_we) tail_mem[tail_wa] <= tail_wd;
    tail_rd <= tail_mem[rd_bkt];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gcvs_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_slot = slot_q;
    rd_bkt  = put_bkt;
    tick_we = 1'b0; tick_wa = slot_q; tick_wd = tick;
    next_we = 1'b0; next_wa = slot_q; next_wd = NONE;
    prev_we = 1'b0; prev_wa = slot_q; prev_wd = NONE;
    cnt_we  = 1'b0; cnt_wa  = slot_q;
    head_we = 1'b0; head_wa = put_bkt; head_wd = NONE;
    tail_we = 1'b0; tail_wa = put_bkt; tail_wd = NONE;
    case (state)
      gcvs_pkg::S_CLEAR: begin
        tick_we = 1'b1; tick_wa = clr[SAW-1:0]; tick_wd = '0;
        head_we = 1'b1; head_wa = clr[BAW-1:0];
        tail_we = 1'b1; tail_wa = clr[BAW-1:0];
        if (clr == '1) state_next = gcvs_pkg::S_IDLE;
      end
      gcvs_pkg::S_IDLE: begin
        if (accept) begin
          state_next = gcvs_pkg::S_RESP;
          if (die_ok) begin
            case (req_type)
              gcvs_pkg::REQ_PUT:
                if (blk_ok && cnt_ok) state_next = gcvs_pkg::S_PUT_RD;
              gcvs_pkg::REQ_REMOVE:
                if (blk_ok) state_next = gcvs_pkg::S_RM_RD;
              gcvs_pkg::REQ_SELECT: state_next = gcvs_pkg::S_SEL_HEAD;
              default: state_next = gcvs_pkg::S_RESP;
            endcase
          end
        end
      end
      gcvs_pkg::S_PUT_RD: begin
        rd_bkt = put_bkt;
        state_next = gcvs_pkg::S_PUT_WR;
      end
      gcvs_pkg::S_PUT_WR: begin
        cnt_we  = 1'b1;
        next_we = 1'b1;
        prev_we = 1'b1; prev_wd = tail_rd;
        tail_we = 1'b1; tail_wd = BW'(blk_q);
        state_next = gcvs_pkg::S_PUT_LINK;
      end
      gcvs_pkg::S_PUT_LINK: begin
        if (tl_q != NONE) begin
          next_we = 1'b1; next_wa = {die_q, BIW'(tl_q)}; next_wd = BW'(blk_q);
        end else begin
          head_we = 1'b1; head_wd = BW'(blk_q);
        end
        state_next = gcvs_pkg::S_RESP;
      end
      gcvs_pkg::S_RM_RD: begin
        rd_slot = slot_q;
        state_next = gcvs_pkg::S_RM_WR;
      end
      gcvs_pkg::S_RM_WR: begin
        head_wa = rm_bkt;
        tail_wa = rm_bkt;
        if (next_rd != NONE && prev_rd != NONE) begin
          next_we = 1'b1; next_wa = {die_q, BIW'(prev_rd)}; next_wd = next_rd;
          prev_we = 1'b1; prev_wa = {die_q, BIW'(next_rd)}; prev_wd = prev_rd;
        end else if (prev_rd != NONE) begin
          next_we = 1'b1; next_wa = {die_q, BIW'(prev_rd)};
          tail_we = 1'b1; tail_wd = prev_rd;
        end else if (next_rd != NONE) begin
          prev_we = 1'b1; prev_wa = {die_q, BIW'(next_rd)};
          head_we = 1'b1; head_wd = next_rd;
        end else begin
          head_we = 1'b1;
          tail_we = 1'b1;
        end
        state_next = sel ? gcvs_pkg::S_SEL_FIN : gcvs_pkg::S_RESP;
      end
      gcvs_pkg::S_SEL_HEAD: begin
        rd_bkt = {die_q, bkt};
        state_next = gcvs_pkg::S_SEL_HWAIT;
      end
      gcvs_pkg::S_SEL_HWAIT: begin
        if (head_rd != NONE) state_next = gcvs_pkg::S_SEL_BRD;
        else if (bkt != PB'(1)) state_next = gcvs_pkg::S_SEL_HEAD;
        else state_next = found ? gcvs_pkg::S_RM_RD : gcvs_pkg::S_RESP;
      end
      gcvs_pkg::S_SEL_BRD: begin
        rd_slot = {die_q, BIW'(cur)};
        state_next = gcvs_pkg::S_SEL_MUL;
      end
      gcvs_pkg::S_SEL_MUL:  state_next = gcvs_pkg::S_SEL_MUL2;
      gcvs_pkg::S_SEL_MUL2: state_next = gcvs_pkg::S_SEL_DIV;
      gcvs_pkg::S_SEL_DIV: begin
        if (dcnt == DCW'(NW - 1)) state_next = gcvs_pkg::S_SEL_CMP;
      end
      gcvs_pkg::S_SEL_CMP: begin
        if (!last_in_list) state_next = gcvs_pkg::S_SEL_BRD;
        else if (bkt != PB'(1)) state_next = gcvs_pkg::S_SEL_HEAD;
        else state_next = (found || win) ? gcvs_pkg::S_RM_RD : gcvs_pkg::S_RESP;
      end
      gcvs_pkg::S_SEL_FIN: begin
        next_we = 1'b1;
        prev_we = 1'b1;
        tick_we = 1'b1;
        state_next = gcvs_pkg::S_RESP;
      end
      gcvs_pkg::S_RESP: begin
        if (!rsp_valid || rsp_ready) state_next = gcvs_pkg::S_IDLE;
      end
      default: state_next = gcvs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr       <= '0;
      tick      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && state != gcvs_pkg::S_RESP) rsp_valid <= 1'b0;
      case (state)
        gcvs_pkg::S_CLEAR: clr <= clr + CLW'(1);
        gcvs_pkg::S_IDLE: begin
          if (accept) begin
            die_q <= DW'(die);
            blk_q <= BIW'(block);
            cnt_q <= invalid_count;
            sel   <= die_ok && (req_type == gcvs_pkg::REQ_SELECT);
            found <= 1'b0;
            best  <= '0;
            bkt   <= PB'(PAGES_PER_BLOCK);
            if (die_ok && req_type == gcvs_pkg::REQ_PUT && blk_ok && cnt_ok &&
                invalid_count != '0) begin
              tick <= tick + TW'(1);
            end
          end
        end
        gcvs_pkg::S_PUT_WR: tl_q <= tail_rd;
        gcvs_pkg::S_SEL_HWAIT: begin
          cur    <= head_rd;
          visits <= '0;
          if (head_rd == NONE) bkt <= bkt - PB'(1);
        end
        gcvs_pkg::S_SEL_MUL: begin
          nx_q   <= next_rd;
          ip_q   <= IPW'(cnt_rd) * IPW'(PAGES_PER_BLOCK);
          age1_q <= tick - tick_rd + TW'(1);
          dvs_q  <= RW'(PAGES_PER_BLOCK) - RW'(cnt_rd) + RW'(1);
        end
        gcvs_pkg::S_SEL_MUL2: begin
          num  <= NW'(ip_q) * NW'(age1_q);
          rem  <= '0;
          quo  <= '0;
          dcnt <= '0;
        end
        gcvs_pkg::S_SEL_DIV: begin
          // restoring division, one quotient bit per cycle
          num  <= num << 1;
          dcnt <= dcnt + DCW'(1);
          if (rem_sh >= {1'b0, dvs_q}) begin
            rem <= RW'(rem_sh - {1'b0, dvs_q});
            quo <= {quo[SW-2:0], 1'b1};
          end else begin
            rem <= RW'(rem_sh);
            quo <= {quo[SW-2:0], 1'b0};
          end
        end
        gcvs_pkg::S_SEL_CMP: begin
          if (win) begin
            best  <= quo;
            blk_q <= BIW'(cur);
            found <= 1'b1;
          end
          visits <= visits + VW'(1);
          cur    <= nx_q;
          if (last_in_list) bkt <= bkt - PB'(1);
        end
        gcvs_pkg::S_RESP: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid    <= 1'b1;
            victim_found <= sel && found;
            victim_block <= (sel && found) ? OBW'(blk_q) : '0;
            victim_score <= (sel && found) ? best : '0;
          end
        end
        default: ;
      endcase
    end
  end

  a_found_score: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && victim_found |-> victim_score != '0)
    else $error("victim reported with zero score");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !victim_found |-> victim_block == '0 && victim_score == '0)
    else $error("non-victim beat carries nonzero payload");

  a_tick_put: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && tick != $past(tick) |->
      $past(accept && req_type == gcvs_pkg::REQ_PUT))
    else $error("activity tick moved without a put");

endmodule

[tb/sv/gc_victim_select_cost_benefit_checker.sv]
module gc_victim_select_cost_benefit_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  input  logic                         req_ready,
  input  logic [gcvs_pkg::TYPE_W-1:0]  req_type,
  input  logic [gcvs_pkg::DIE_W-1:0]   die,
  input  logic [gcvs_pkg::BLK_W-1:0]   block,
  input  logic [gcvs_pkg::CNT_W-1:0]   invalid_count,
  input  logic                         rsp_valid,
  input  logic                         rsp_ready,
  input  logic                         victim_found,
  input  logic [gcvs_pkg::BLK_W-1:0]   victim_block,
  input  logic [gcvs_pkg::SCORE_W-1:0] victim_score,
  output int                           errors,
  output int                           outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TYW  = gcvs_pkg::TYPE_W;
  localparam int BW   = gcvs_pkg::BLK_W;
  localparam int CW   = gcvs_pkg::CNT_W;
  localparam int SW   = gcvs_pkg::SCORE_W;
  localparam int TKW  = gcvs_pkg::TICK_W;
  localparam int NDIE = gcvs_pkg::DIES_DEF;
  localparam int NBLK = gcvs_pkg::BLOCKS_DEF;
  localparam int NPG  = gcvs_pkg::PAGES_DEF;
  localparam int NBKT = NPG + 1;
  localparam logic [BW:0] NONE = (BW+1)'(NBLK);

  typedef struct {
    logic          found;
    logic [BW-1:0] blk;
    logic [SW-1:0] score;
  } victim_t;

  logic [TKW-1:0] tick;
  logic [TKW-1:0] erase_tick [NDIE*NBLK];
  logic [BW:0]    head [NDIE*NBKT];
  logic [BW:0]    tail [NDIE*NBKT];
  logic [BW:0]    nxt  [NDIE*NBLK];
  logic [BW:0]    prv  [NDIE*NBLK];
  logic [CW-1:0]  cnt_of [NDIE*NBLK];
  victim_t        victim_q [$];

  function automatic logic [SW-1:0] score_of(int base, int b);
    longint unsigned inv, age1, benefit;
    logic [TKW-1:0] a;
    inv = cnt_of[base+b];
    a = tick - erase_tick[base+b] + TKW'(1);
    age1 = a;
    benefit = inv * age1 * NPG;
    return SW'(benefit / (NPG - inv + 1));
  endfunction

  function automatic void unlink(int d, int b);
    int base, bk;
    logic [BW:0] nx, pv;
    base = d * NBLK;
    bk = d * NBKT + cnt_of[base+b];
    nx = nxt[base+b];
    pv = prv[base+b];
    if (nx != NONE && pv != NONE) begin
      nxt[base+pv] = nx;
      prv[base+nx] = pv;
    end else if (pv != NONE) begin
      nxt[base+pv] = NONE;
      tail[bk] = pv;
    end else if (nx != NONE) begin
      prv[base+nx] = NONE;
      head[bk] = nx;
    end else begin
      head[bk] = NONE;
      tail[bk] = NONE;
    end
  endfunction

  function automatic victim_t apply_request(logic [TYW-1:0] t, int d, int b, int c);
    victim_t r;
    int base, bk, visits;
    logic [BW:0] p, nx, tl;
    logic [SW-1:0] s;
    r = '{1'b0, '0, '0};
    base = d * NBLK;
    if (t == gcvs_pkg::REQ_PUT && c <= NPG) begin
      bk = d * NBKT + c;
      tl = tail[bk];
      if (c != 0) tick++;
      cnt_of[base+b] = CW'(c);
      nxt[base+b] = NONE;
      if (tl != NONE) begin
        prv[base+b] = tl;
        nxt[base+tl] = (BW+1)'(b);
      end else begin
        prv[base+b] = NONE;
        head[bk] = (BW+1)'(b);
      end
      tail[bk] = (BW+1)'(b);
    end else if (t == gcvs_pkg::REQ_REMOVE) begin
      unlink(d, b);
    end else if (t == gcvs_pkg::REQ_SELECT) begin
      for (int k = NPG; k > 0; k--) begin
        p = head[d*NBKT+k];
        visits = 0;
        while (p != NONE && visits < NBLK) begin
          nx = nxt[base+p];
          s = score_of(base, p);
          if (s > r.score) begin
            r.score = s;
            r.blk = BW'(p);
            r.found = 1'b1;
          end
          p = nx;
          visits++;
        end
      end
      if (r.found) begin
        unlink(d, r.blk);
        nxt[base+r.blk] = NONE;
        prv[base+r.blk] = NONE;
        erase_tick[base+r.blk] = tick;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    victim_t e;
    if (rst) begin
      errors = 0;
      tick = '0;
      foreach (erase_tick[i]) begin
        erase_tick[i] = '0;
        nxt[i] = '0;
        prv[i] = '0;
        cnt_of[i] = '0;
      end
      foreach (head[i]) begin
        head[i] = NONE;
        tail[i] = NONE;
      end
      victim_q.delete();
    end else begin
      if (req_valid && req_ready)
        victim_q.push_back(apply_request(req_type, die, block, invalid_count));
      if (rsp_valid && rsp_ready) begin
        if (victim_q.size() == 0) begin
          $error("response beat with nothing expected");
          errors++;
        end else begin
          e = victim_q.pop_front();
          if (victim_found !== e.found) begin
            $error("victim_found expected %0d actual %0d", e.found, victim_found);
            errors++;
          end
          if (victim_block !== e.blk) begin
            $error("victim_block expected %0d actual %0d", e.blk, victim_block);
            errors++;
          end
          if (victim_score !== e.score) begin
            $error("victim_score expected %0d actual %0d", e.score, victim_score);
            errors++;
          end
        end
      end
    end
    outstanding = victim_q.size();
  end

endmodule

[tb/sv/gc_victim_select_cost_benefit_top_tb.sv]
module gc_victim_select_cost_benefit_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TYW  = gcvs_pkg::TYPE_W;
  localparam int DW   = gcvs_pkg::DIE_W;
  localparam int BW   = gcvs_pkg::BLK_W;
  localparam int CW   = gcvs_pkg::CNT_W;
  localparam int SW   = gcvs_pkg::SCORE_W;
  localparam int NDIE = gcvs_pkg::DIES_DEF;
  localparam logic [TYW-1:0] REQ_PUT    = gcvs_pkg::REQ_PUT;
  localparam logic [TYW-1:0] REQ_REMOVE = gcvs_pkg::REQ_REMOVE;
  localparam logic [TYW-1:0] REQ_SELECT = gcvs_pkg::REQ_SELECT;
  localparam logic [TYW-1:0] REQ_UNUSED = 2'd3;
  localparam int NBLK = gcvs_pkg::BLOCKS_DEF;
  localparam int NPG = gcvs_pkg::PAGES_DEF;
  localparam int MAX_LISTED = 16;
  localparam int N_RANDOM = 1600;
  localparam longint CYCLE_LIMIT = 8_000_000;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_ready;
  logic [TYW-1:0] req_type = '0;
  logic [DW-1:0]  die = '0;
  logic [BW-1:0]  block = '0;
  logic [CW-1:0]  invalid_count = '0;
  logic           rsp_valid;
  logic           rsp_ready = 1'b0;
  logic           victim_found;
  logic [BW-1:0]  victim_block;
  logic [SW-1:0]  victim_score;
  int             errors, outstanding;

  logic   quiet = 1'b0;
  logic   hold_rsp = 1'b0;
  longint cycles = 0;

  // block bookkeeping so removes only touch blocks whose links exist
  bit listed  [NDIE*NBLK];
  int listed_n [NDIE];
  int sel_die_q [$];

  gc_victim_select_cost_benefit_top dut (.*);

  gc_victim_select_cost_benefit_checker chk (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // track victims so later removes stay on listed blocks
  always @(posedge clk) begin
    int d;
    if (!rst && rsp_valid && rsp_ready && sel_die_q.size() > 0) begin
      d = sel_die_q.pop_front();
      if (d >= 0 && victim_found && listed[d*NBLK+victim_block]) begin
        listed[d*NBLK+victim_block] = 0;
        listed_n[d]--;
      end
    end
  end

  initial begin
    forever begin
      int stall;
      stall = quiet ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        rsp_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      while (hold_rsp) begin
        rsp_ready = 1'b0;
        @(negedge clk);
      end
      rsp_ready = 1'b1;
      do @(posedge clk); while (!rsp_valid);
      @(negedge clk);
    end
  end

  task automatic send(logic [TYW-1:0] t, int d, int b, int c);
    int gap, slot;
    gap = quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid = 1'b1;
    req_type = t;
    die = DW'(d);
    block = BW'(b);
    invalid_count = CW'(c);
    do @(posedge clk); while (!req_ready);
    slot = d * NBLK + b;
    sel_die_q.push_back(t == REQ_SELECT ? d : -1);
    if (t == REQ_PUT && c <= NPG) begin
      if (!listed[slot]) listed_n[d]++;
      listed[slot] = 1;
    end else if (t == REQ_REMOVE && listed[slot]) begin
      listed[slot] = 0;
      listed_n[d]--;
    end
    @(negedge clk);
  endtask

  task automatic drain();
    req_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  function automatic int pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 20) return NPG;
    if (r < 28) return $urandom_range(NPG + 1, 255);
    return $urandom_range(1, NPG);
  endfunction

  initial begin
    int d, b, r, c;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // directed: empty select, count extremes, ties, oversized counts, unused code
    send(REQ_SELECT, 0, 0, 0);
    send(REQ_PUT, 0, 0, 0);
    send(REQ_SELECT, 0, 0, 0);
    send(REQ_PUT, 7, 1023, NPG);
    send(REQ_PUT, 0, 5, 200);
    send(REQ_PUT, 0, 6, 255);
    send(REQ_PUT, 0, 1, 1);
    send(REQ_PUT, 0, 2, 1);
    send(REQ_PUT, 0, 3, 64);
    send(REQ_PUT, 0, 4, 64);
    send(REQ_PUT, 0, 7, 64);
    send(REQ_REMOVE, 0, 4, 0);
    send(REQ_SELECT, 0, 0, 0);
    send(REQ_SELECT, 0, 0, 0);
    send(REQ_REMOVE, 0, 0, 0);
    send(REQ_REMOVE, 0, 7, 0);
    send(REQ_SELECT, 0, 1023, 255);
    send(REQ_UNUSED, 7, 1023, 255);
    send(REQ_SELECT, 7, 0, 0);
    send(REQ_SELECT, 7, 0, 0);
    send(REQ_PUT, 3, 512, 129);
    send(REQ_SELECT, 3, 0, 0);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (i == 400) begin
        fork
          begin
            hold_rsp = 1'b1;
            repeat (2000) @(negedge clk);
            hold_rsp = 1'b0;
          end
        join_none
      end
      if (i == 800) begin
        drain();
        repeat (50) @(negedge clk);
      end
      d = $urandom_range(0, NDIE - 1);
      r = $urandom_range(0, 99);
      if (r < 45 && listed_n[d] >= MAX_LISTED) r = 50;
      if (r >= 45 && r < 75 && listed_n[d] == 0) r = 0;
      if (r < 45) begin
        c = pick_count();
        do b = $urandom_range(0, NBLK - 1); while (listed[d*NBLK+b]);
        send(REQ_PUT, d, b, c);
      end else if (r < 75) begin
        do b = $urandom_range(0, NBLK - 1); while (!listed[d*NBLK+b]);
        send(REQ_REMOVE, d, b, $urandom_range(0, 255));
      end else if (r < 93) begin
        send(REQ_SELECT, d, $urandom_range(0, NBLK - 1), $urandom_range(0, 255));
      end else begin
        send(REQ_UNUSED, d, $urandom_range(0, NBLK - 1), $urandom_range(0, 255));
      end
    end

    // list misuse at the end: double put makes a self loop, then double remove
    quiet = 1'b0;
    drain();
    send(REQ_PUT, 6, 10, 5);
    send(REQ_PUT, 6, 10, 5);
    send(REQ_SELECT, 6, 0, 0);
    send(REQ_PUT, 6, 11, 9);
    send(REQ_REMOVE, 6, 11, 0);
    send(REQ_REMOVE, 6, 11, 0);
    send(REQ_SELECT, 6, 0, 0);

    drain();
    repeat (200) @(negedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
